// ----- hw/rtl/frc_pkg.sv -----
package frc_pkg;

  localparam int WORD_BITS    = 64;
  localparam int NUM_BITS     = 64;
  localparam int DEN_BITS     = 63;
  localparam int SHIFT_BITS   = $clog2(WORD_BITS);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NAN     = 2'd1;
  localparam logic [1:0] ST_POS_INF = 2'd2;
  localparam logic [1:0] ST_NEG_INF = 2'd3;

  typedef logic [WORD_BITS-1:0] word_t;

  // classified request handed from front to back
  typedef struct packed {
    logic       special;
    logic [1:0] status;
    logic       neg;
    word_t      num_mag;
    word_t      den_mag;
  } frc_item_t;

endpackage

// ----- hw/rtl/frc_in_if.sv -----
interface frc_in_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] numerator;
  logic signed [63:0] denominator;

  modport source (output valid, numerator, denominator, input ready);
  modport sink   (input valid, numerator, denominator, output ready);
endinterface

// ----- hw/rtl/frc_out_if.sv -----
interface frc_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] reduced_numerator;
  logic        [62:0] reduced_denominator;
  logic        [1:0]  status;

  modport source (output valid, reduced_numerator, reduced_denominator, status, input ready);
  modport sink   (input valid, reduced_numerator, reduced_denominator, status, output ready);
endinterface

// ----- hw/rtl/frc_front.sv -----
module frc_front
  import frc_pkg::*;
(
  frc_in_if.sink    operand,
  input  logic      q_ready,
  output logic      push,
  output frc_item_t item
);

  word_t n;
  word_t d;
  logic  n_neg;
  logic  d_neg;
  word_t n_mag;
  word_t d_mag;

  always_comb begin
    n     = operand.numerator[WORD_BITS-1:0];
    d     = operand.denominator[WORD_BITS-1:0];
    n_neg = n[WORD_BITS-1];
    d_neg = d[WORD_BITS-1];
    n_mag = n_neg ? (~n + word_t'(1)) : n;
    d_mag = d_neg ? (~d + word_t'(1)) : d;

    item.num_mag = n_mag;
    item.den_mag = d_mag;
    item.neg     = (n_neg != d_neg) && (n_mag != '0);
    item.special = (d == '0);
    if (d != '0) begin
      item.status = ST_OK;
    end else if (n == '0) begin
      item.status = ST_NAN;
    end else if (n_neg) begin
      item.status = ST_NEG_INF;
    end else begin
      item.status = ST_POS_INF;
    end
  end

  assign operand.ready = q_ready;
  assign push          = operand.valid && q_ready;

endmodule

// ----- hw/rtl/frc_queue.sv -----
module frc_queue
  import frc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  frc_item_t push_item,
  output logic      not_full,
  input  logic      pop,
  output logic      not_empty,
  output frc_item_t pop_item
);

  frc_item_t            slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign not_full  = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && not_full) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && not_full) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push && not_full, pop && not_empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/frc_back.sv -----
module frc_back
  import frc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  frc_item_t q_item,
  output logic      pop,
  frc_out_if.source result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GCD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam word_t MAX_POS = {1'b0, {(WORD_BITS-1){1'b1}}};

  logic [1:0]            state;
  word_t                 a;
  word_t                 b;
  logic [SHIFT_BITS-1:0] k;
  word_t                 g;
  word_t                 quo_n;
  word_t                 quo_d;
  word_t                 rem_n;
  word_t                 rem_d;
  logic [SHIFT_BITS-1:0] cnt;
  logic                  neg;
  logic                  special;
  logic [1:0]            status;

  logic [WORD_BITS:0]    trial_n;
  logic [WORD_BITS:0]    trial_d;
  logic                  fit_n;
  logic                  fit_d;
  word_t                 rn;
  word_t                 rd;
  logic                  load;

  // one restoring-division step for each quotient
  always_comb begin
    trial_n = {rem_n, quo_n[WORD_BITS-1]};
    trial_d = {rem_d, quo_d[WORD_BITS-1]};
    fit_n   = (trial_n >= {1'b0, g});
    fit_d   = (trial_d >= {1'b0, g});
  end

  always_comb begin
    if (special) begin
      rn = '0;
      rd = '0;
    end else begin
      if (neg) begin
        rn = ~quo_n + word_t'(1);
      end else begin
        rn = (quo_n > MAX_POS) ? MAX_POS : quo_n;
      end
      rd = (quo_d > MAX_POS) ? MAX_POS : quo_d;
    end
  end

  assign pop  = (state == S_IDLE) && q_valid;
  assign load = (state == S_DONE) && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= q_item.special ? S_DONE : S_GCD;
          end
        end
        S_GCD: begin
          if (a == '0) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        a       <= q_item.num_mag;
        b       <= q_item.den_mag;
        quo_n   <= q_item.num_mag;
        quo_d   <= q_item.den_mag;
        neg     <= q_item.neg;
        special <= q_item.special;
        status  <= q_item.status;
        k       <= '0;
      end
      S_GCD: begin
        // binary gcd: strip shared twos into k, then subtract odd parts
        if (a == '0) begin
          g     <= b << k;
          rem_n <= '0;
          rem_d <= '0;
          cnt   <= SHIFT_BITS'(WORD_BITS - 1);
        end else if (!a[0] && !b[0]) begin
          a <= a >> 1;
          b <= b >> 1;
          k <= k + 1'b1;
        end else if (!a[0]) begin
          a <= a >> 1;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else if (a >= b) begin
          a <= (a - b) >> 1;
        end else begin
          a <= (b - a) >> 1;
          b <= a;
        end
      end
      S_DIV: begin
        rem_n <= fit_n ? word_t'(trial_n - {1'b0, g}) : trial_n[WORD_BITS-1:0];
        rem_d <= fit_d ? word_t'(trial_d - {1'b0, g}) : trial_d[WORD_BITS-1:0];
        quo_n <= {quo_n[WORD_BITS-2:0], fit_n};
        quo_d <= {quo_d[WORD_BITS-2:0], fit_d};
        cnt   <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.reduced_numerator   <= NUM_BITS'(signed'(rn));
      result.reduced_denominator <= DEN_BITS'(rd);
      result.status              <= status;
    end
  end

endmodule

// ----- hw/rtl/fraction_reducer.sv -----
// Fraction reducer: brings a signed numerator/denominator pair to lowest terms.
// operand (sink): numerator, denominator, each 64-bit two's complement.
// result (source): reduced_numerator (signed), reduced_denominator (positive),
//   status (ok, zero over zero, +inf, -inf). One result per request, in order.
// The front classifies each request (sign, magnitudes, zero denominator) and
// writes it to a two-entry queue; operand.ready is high while the queue has room.
// The back takes one request at a time: a binary gcd that does one shift or
// subtract per cycle, then two restoring dividers that form both quotients in
// parallel, one bit per cycle.
// Sustained throughput is set by the gcd loop and the bit-serial dividers.
// The result sits in an output register; while the receiver stalls the back
// finishes its current request and holds it, and the queue keeps taking
// requests until full.
// Reset (rst, synchronous) empties the queue, idles the back and drops
// result.valid.
module fraction_reducer
  import frc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  frc_in_if.sink    operand,
  frc_out_if.source result
);

  logic      push;
  logic      q_ready;
  frc_item_t push_item;
  logic      pop;
  logic      q_valid;
  frc_item_t pop_item;

  frc_front u_front (
    .operand (operand),
    .q_ready (q_ready),
    .push    (push),
    .item    (push_item)
  );

  frc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .not_full  (q_ready),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_item  (pop_item)
  );

  frc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (pop_item),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ----- tb/fraction_reducer_tb.sv -----
module fraction_reducer_tb
  import frc_pkg::*;
();

  localparam int RANDOM_ITEMS = 550;
  localparam int CALM_ITEMS   = 100;
  localparam int PAUSE_AT     = 250;
  localparam int DRAIN_CYCLES = 250;

  localparam logic signed [63:0] MAX_WORD = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN_WORD = 64'sh8000_0000_0000_0000;
  localparam logic [62:0]        MAX_DEN  = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [63:0] num;
    logic [62:0]        den;
    logic [1:0]         status;
  } fraction_t;

  typedef struct {
    logic signed [63:0] num;
    logic signed [63:0] den;
    logic               typed;
    fraction_t          want;
  } directed_row_t;

  logic clk;
  logic rst;
  logic calm;
  int   errors;

  fraction_t     lowest_terms_q[$];
  fraction_t     want;
  directed_row_t directed_rows[$];

  frc_in_if  operand_if ();
  frc_out_if result_if ();

  fraction_reducer uut (
    .clk(clk),
    .rst(rst),
    .operand(operand_if),
    .result(result_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic fraction_t reduce_fraction(input word_t n, input word_t d);
    word_t     nm, dm, a, b, t, g;
    word_t     maxpos;
    logic      neg;
    fraction_t r;
    maxpos = {1'b0, {(WORD_BITS-1){1'b1}}};
    r = '0;
    if (d == '0) begin
      if (n == '0) r.status = ST_NAN;
      else r.status = n[WORD_BITS-1] ? ST_NEG_INF : ST_POS_INF;
      return r;
    end
    nm = n[WORD_BITS-1] ? -n : n;
    dm = d[WORD_BITS-1] ? -d : d;
    neg = (n[WORD_BITS-1] != d[WORD_BITS-1]) && (nm != '0);
    a = nm;
    b = dm;
    while (b != '0) begin
      t = a % b;
      a = b;
      b = t;
    end
    g = (a == '0) ? word_t'(1) : a;
    nm = nm / g;
    dm = dm / g;
    if (neg) r.num = -nm;
    else r.num = (nm > maxpos) ? maxpos : nm;
    if (dm > maxpos) dm = maxpos;
    r.den = dm[62:0];
    r.status = ST_OK;
    return r;
  endfunction

  function automatic logic signed [63:0] boundary_word();
    case ($urandom_range(0, 5))
      0: return MIN_WORD;
      1: return MAX_WORD;
      2: return 64'sd1 << $urandom_range(0, 62);
      3: return -(64'sd1 << $urandom_range(0, 62));
      4: return 64'($urandom_range(0, 2)) - 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_request(input logic signed [63:0] n, input logic signed [63:0] d,
                              input fraction_t expected);
    operand_if.valid <= 1'b1;
    operand_if.numerator <= n;
    operand_if.denominator <= d;
    @(posedge clk);
    while (!operand_if.ready) @(posedge clk);
    lowest_terms_q.push_back(expected);
    if (!calm && $urandom_range(0, 3) == 0) begin
      operand_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // result side: random stall bursts, always ready once calm
  initial begin
    int burst;
    result_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      burst = $urandom_range(1, 16);
      result_if.ready <= calm || ($urandom_range(0, 2) != 0);
      repeat (burst) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (lowest_terms_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result %0d/%0d status %0d", result_if.reduced_numerator,
                   result_if.reduced_denominator, result_if.status);
      end else begin
        want = lowest_terms_q.pop_front();
        if (result_if.reduced_numerator !== want.num ||
            result_if.reduced_denominator !== want.den ||
            result_if.status !== want.status) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: got %0d/%0d status %0d, want %0d/%0d status %0d",
                     result_if.reduced_numerator, result_if.reduced_denominator,
                     result_if.status, want.num, want.den, want.status);
        end
      end
    end
  end

  initial begin
    #6_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic signed [63:0] n, d;
    word_t              a, b, g;
    int                 pick;
    errors = 0;
    calm = 1'b0;
    rst <= 1'b1;
    operand_if.valid <= 1'b0;
    operand_if.numerator <= '0;
    operand_if.denominator <= '0;

    // zero denominators
    directed_rows.push_back('{64'sd0, 64'sd0, 1'b1, '{64'sd0, 63'd0, ST_NAN}});
    directed_rows.push_back('{64'sd5, 64'sd0, 1'b1, '{64'sd0, 63'd0, ST_POS_INF}});
    directed_rows.push_back('{-64'sd5, 64'sd0, 1'b1, '{64'sd0, 63'd0, ST_NEG_INF}});
    directed_rows.push_back('{MAX_WORD, 64'sd0, 1'b1, '{64'sd0, 63'd0, ST_POS_INF}});
    directed_rows.push_back('{MIN_WORD, 64'sd0, 1'b1, '{64'sd0, 63'd0, ST_NEG_INF}});
    // zero numerator
    directed_rows.push_back('{64'sd0, 64'sd7, 1'b1, '{64'sd0, 63'd1, ST_OK}});
    directed_rows.push_back('{64'sd0, -64'sd7, 1'b1, '{64'sd0, 63'd1, ST_OK}});
    // sign combinations
    directed_rows.push_back('{64'sd6, 64'sd4, 1'b0, '0});
    directed_rows.push_back('{-64'sd6, 64'sd4, 1'b0, '0});
    directed_rows.push_back('{64'sd6, -64'sd4, 1'b0, '0});
    directed_rows.push_back('{-64'sd6, -64'sd4, 1'b0, '0});
    directed_rows.push_back('{-64'sd1, -64'sd1, 1'b1, '{64'sd1, 63'd1, ST_OK}});
    // extremes
    directed_rows.push_back('{MAX_WORD, MAX_WORD, 1'b1, '{64'sd1, 63'd1, ST_OK}});
    directed_rows.push_back('{MAX_WORD, 64'sd1, 1'b1, '{MAX_WORD, 63'd1, ST_OK}});
    directed_rows.push_back('{-MAX_WORD, 64'sd1, 1'b1, '{-MAX_WORD, 63'd1, ST_OK}});
    directed_rows.push_back('{64'sd1, MAX_WORD, 1'b1, '{64'sd1, MAX_DEN, ST_OK}});
    directed_rows.push_back('{64'sd1, -MAX_WORD, 1'b1, '{-64'sd1, MAX_DEN, ST_OK}});
    // most negative word, with saturation
    directed_rows.push_back('{MIN_WORD, 64'sd1, 1'b1, '{MIN_WORD, 63'd1, ST_OK}});
    directed_rows.push_back('{MIN_WORD, -64'sd1, 1'b1, '{MAX_WORD, 63'd1, ST_OK}});
    directed_rows.push_back('{64'sd1, MIN_WORD, 1'b1, '{-64'sd1, MAX_DEN, ST_OK}});
    directed_rows.push_back('{-64'sd1, MIN_WORD, 1'b1, '{64'sd1, MAX_DEN, ST_OK}});
    directed_rows.push_back('{MIN_WORD, MIN_WORD, 1'b1, '{64'sd1, 63'd1, ST_OK}});
    directed_rows.push_back('{MIN_WORD, 64'sd2, 1'b0, '0});
    // consecutive Fibonacci numbers
    directed_rows.push_back('{64'sd7540113804746346429, 64'sd4660046610375530309, 1'b0, '0});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].num, directed_rows[i].den,
                   directed_rows[i].typed ? directed_rows[i].want :
                   reduce_fraction(directed_rows[i].num, directed_rows[i].den));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
      if (i == PAUSE_AT) begin
        operand_if.valid <= 1'b0;
        @(posedge clk);
        while (lowest_terms_q.size() != 0) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        n = {$urandom, $urandom};
        d = {$urandom, $urandom};
      end else if (pick < 60) begin
        // shared factor g, so the gcd is a multiple of g
        g = $urandom_range(0, 1) ? word_t'($urandom_range(1, 1000))
                                 : word_t'($urandom_range(1, 32'h7FFF_FFFF));
        a = word_t'($urandom);
        b = word_t'($urandom_range(1, 32'hFFFF_FFFF));
        n = a * g;
        d = b * g;
        if ($urandom_range(0, 1)) n = -n;
        if ($urandom_range(0, 1)) d = -d;
      end else if (pick < 72) begin
        n = 64'($urandom_range(0, 40)) - 64'd20;
        d = 64'($urandom_range(0, 40)) - 64'd20;
      end else if (pick < 82) begin
        n = $urandom_range(0, 3) == 0 ? 64'sd0 : boundary_word();
        d = 64'sd0;
      end else begin
        n = boundary_word();
        d = boundary_word();
      end
      send_request(n, d, reduce_fraction(n, d));
    end
    operand_if.valid <= 1'b0;

    while (lowest_terms_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/frc_pkg.sv
hw/rtl/frc_in_if.sv
hw/rtl/frc_out_if.sv
hw/rtl/frc_front.sv
hw/rtl/frc_queue.sv
hw/rtl/frc_back.sv
hw/rtl/fraction_reducer.sv
tb/fraction_reducer_tb.sv
